// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. Each use is clocked on clk and is
// disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that is checked on every rising edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A property that must be true on every rising edge outside of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`endif

// ===== rtl/lst_pkg.sv =====
// ---------------------------------------------------------------------------
// lst_pkg
// Types and constants shared by the ordered list sequencer, its storage and
// the top level.
// ---------------------------------------------------------------------------
package lst_pkg;

	// Number of entries the list can hold.
	localparam int CAPACITY = 16;
	localparam int ADDR_W   = $clog2(CAPACITY);

	// Fixed field widths of the command and result transactions.
	localparam int MODE_W   = 3;
	localparam int POS_W    = 5;
	localparam int CNT_W    = 5;
	localparam int STATUS_W = 2;
	localparam int VALUE_W  = 32;
	localparam int RDVAL_W  = 32;

	// Command codes.
	localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_INSERT = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ERASE  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd5;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

	// Sequencer states, one-hot.
	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_SHIFT_RD = 7'b0000010,
		S_SHIFT_WR = 7'b0000100,
		S_FINAL_WR = 7'b0001000,
		S_READ_RD  = 7'b0010000,
		S_READ_CAP = 7'b0100000,
		S_DONE     = 7'b1000000
	} seq_state_t;

	// Control from the sequencer to the entry storage.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

// ===== rtl/indexed_insert_erase_list.sv =====
// Remove, clear, failed commands and unused codes go straight to the done state; append
// writes the word first; read reads the entry and then captures it; insert moves each entry
// from the end down to the position up by one (a read state, then a write state) before
// writing the word; erase moves each entry above the position down by one. The next command
// is taken in the cycle after a result is loaded, never while a command is in flight.
// Reset (arst_n low) empties the list and drops any pending result; the entry
// storage is not cleared, since only entries below the count are ever read.
// ---------------------------------------------------------------------------
// indexed_insert_erase_list
// Fixed-capacity ordered list of data words driven by a command stream.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module indexed_insert_erase_list #(
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// Command stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	// Fields from bit 0 up: mode[2:0], position[7:3], value[39:8].
	input  logic [39:0] s_tdata,
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	// Fields from bit 0 up: read_value[31:0], entry_count[36:32],
	// status[38:37], zero padding[39].
	output logic [39:0] m_tdata
);
	import lst_pkg::*;

	// Command fields unpacked from the incoming transaction.
	logic [MODE_W-1:0]  mode;
	logic [POS_W-1:0]   position;
	logic [VALUE_W-1:0] value;

	assign mode     = s_tdata[2:0];
	assign position = s_tdata[7:3];
	assign value    = s_tdata[39:8];

	// The stored word keeps DATA_WIDTH bits of the value; a wide
	// intermediate handles both narrower and wider storage words.
	logic [63:0]           value_ext;
	logic [DATA_WIDTH-1:0] word;

	assign value_ext = 64'(value);
	assign word      = value_ext[DATA_WIDTH-1:0];

	// The sequencer takes a command only when it is idle. A command is in
	// flight from its accepting edge until its result is loaded into the
	// output register, so the next command may arrive while the previous
	// result still waits there.
	logic                  accept;
	logic                  out_free;
	logic                  seq_idle;
	logic                  seq_done;
	logic [DATA_WIDTH-1:0] rd_word;
	logic [CNT_W-1:0]      count;
	logic [STATUS_W-1:0]   status;
	mem_req_t              mem_req;
	logic [DATA_WIDTH-1:0] mem_wdata;
	logic [DATA_WIDTH-1:0] mem_rdata;

	assign s_tready = seq_idle;
	assign accept   = s_tvalid && s_tready;

	lst_seq #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.mode      (mode),
		.position  (position),
		.word      (word),
		.out_free  (out_free),
		.idle      (seq_idle),
		.done      (seq_done),
		.rd_word   (rd_word),
		.count     (count),
		.status    (status),
		.mem_req   (mem_req),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	lst_mem #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_mem (
		.clk   (clk),
		.req   (mem_req),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Output register. A finished result is loaded when the register is
	// empty or its current transaction completes in the same cycle.
	logic [63:0]        rd_ext;
	logic               m_tvalid_q;
	logic [39:0]        m_tdata_q;

	assign rd_ext   = 64'(rd_word);
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (seq_done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_done) begin
			m_tdata_q <= {1'b0, status, count, rd_ext[RDVAL_W-1:0]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// The sequencer leaves the idle state on every accepted command, so it is
	// busy right after it accepts one.
	`ASSERT_CLK(a_busy_after_accept, accept |=> !s_tready, "ready right after accept")
	// The entry count never exceeds the capacity.
	`ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(CAPACITY), "entry count above capacity")
	// A result is loaded only into a free output register.
	`ASSERT_CLK(a_no_overwrite, seq_done |-> (!m_tvalid_q || m_tready), "result overwritten")

endmodule

// ===== rtl/lst_mem.sv =====
// ---------------------------------------------------------------------------
// lst_mem
// Entry storage of the list: one write port and one read port with
// registered read data.
// ---------------------------------------------------------------------------
module lst_mem #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  lst_pkg::mem_req_t     req,
	input  logic [DATA_WIDTH-1:0] wdata,
	output logic [DATA_WIDTH-1:0] rdata
);
	import lst_pkg::*;

	logic [DATA_WIDTH-1:0] mem_q [CAPACITY];
	logic [DATA_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/lst_seq.sv =====
// ---------------------------------------------------------------------------
// lst_seq
// Command sequencer of the ordered list. It checks a command against the
// entry count, then moves entries one at a time through the storage with a
// shared index step and compare unit.
// ---------------------------------------------------------------------------
module lst_seq #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lst_pkg::MODE_W-1:0]    mode,
	input  logic [lst_pkg::POS_W-1:0]     position,
	input  logic [DATA_WIDTH-1:0]         word,
	input  logic                          out_free,
	output logic                          idle,
	output logic                          done,
	output logic [DATA_WIDTH-1:0]         rd_word,
	output logic [lst_pkg::CNT_W-1:0]     count,
	output logic [lst_pkg::STATUS_W-1:0]  status,
	output lst_pkg::mem_req_t             mem_req,
	output logic [DATA_WIDTH-1:0]         mem_wdata,
	input  logic [DATA_WIDTH-1:0]         mem_rdata
);
	import lst_pkg::*;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

	seq_state_t            state_q;
	logic [CNT_W-1:0]      count_q;
	logic [MODE_W-1:0]     mode_q;
	logic [DATA_WIDTH-1:0] word_q;
	logic [CNT_W-1:0]      idx_q;
	logic [CNT_W-1:0]      limit_q;
	logic [STATUS_W-1:0]   status_q;
	logic [DATA_WIDTH-1:0] rd_q;

	// Shared index unit: one step toward the far end of the move and one
	// compare against the stop index.
	logic             dir_up;
	logic [CNT_W-1:0] idx_step;
	logic             more;

	assign dir_up   = (mode_q == MODE_ERASE);
	assign idx_step = dir_up ? (idx_q + ONE) : (idx_q - ONE);
	assign more     = dir_up ? (idx_step < limit_q) : (idx_step > limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_DONE;
						case (mode)
							MODE_APPEND: begin
								if (count_q < CAP_CNT) begin
									state_q <= S_FINAL_WR;
								end
							end
							MODE_REMOVE: begin
								if (count_q != '0) begin
									count_q <= count_q - ONE;
								end
							end
							MODE_INSERT: begin
								if (position <= count_q && count_q < CAP_CNT) begin
									state_q <= (count_q > position) ? S_SHIFT_RD : S_FINAL_WR;
								end
							end
							MODE_ERASE: begin
								if (count_q != '0 && position < count_q) begin
									if (position < count_q - ONE) begin
										state_q <= S_SHIFT_RD;
									end else begin
										count_q <= count_q - ONE;
									end
								end
							end
							MODE_READ: begin
								if (count_q != '0 && position < count_q) begin
									state_q <= S_READ_RD;
								end
							end
							MODE_CLEAR: begin
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_SHIFT_RD: begin
					state_q <= S_SHIFT_WR;
				end
				S_SHIFT_WR: begin
					if (more) begin
						state_q <= S_SHIFT_RD;
					end else if (dir_up) begin
						count_q <= count_q - ONE;
						state_q <= S_DONE;
					end else begin
						state_q <= S_FINAL_WR;
					end
				end
				S_FINAL_WR: begin
					count_q <= count_q + ONE;
					state_q <= S_DONE;
				end
				S_READ_RD: begin
					state_q <= S_READ_CAP;
				end
				S_READ_CAP: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command payload, status and walking index.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					mode_q   <= mode;
					word_q   <= word;
					rd_q     <= '0;
					status_q <= ST_OK;
					idx_q    <= position;
					limit_q  <= position;
					case (mode)
						MODE_APPEND: begin
							idx_q <= count_q;
							if (count_q >= CAP_CNT) begin
								status_q <= ST_FULL;
							end
						end
						MODE_REMOVE: begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
							end
						end
						MODE_INSERT: begin
							idx_q <= count_q;
							if (position > count_q) begin
								status_q <= ST_RANGE;
							end else if (count_q >= CAP_CNT) begin
								status_q <= ST_FULL;
							end
						end
						MODE_ERASE, MODE_READ: begin
							limit_q <= count_q - ONE;
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
							end else if (position >= count_q) begin
								status_q <= ST_RANGE;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SHIFT_WR: begin
				idx_q <= idx_step;
			end
			S_READ_CAP: begin
				rd_q <= mem_rdata;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		mem_req.re    = (state_q == S_SHIFT_RD) || (state_q == S_READ_RD);
		mem_req.raddr = (state_q == S_SHIFT_RD) ? idx_step[ADDR_W-1:0] : idx_q[ADDR_W-1:0];
		mem_req.we    = (state_q == S_SHIFT_WR) || (state_q == S_FINAL_WR);
		mem_req.waddr = idx_q[ADDR_W-1:0];
	end

	assign mem_wdata = (state_q == S_FINAL_WR) ? word_q : mem_rdata;

	assign idle    = (state_q == S_IDLE);
	assign done    = (state_q == S_DONE) && out_free;
	assign rd_word = rd_q;
	assign count   = count_q;
	assign status  = status_q;

endmodule
